@@ hdl/piddom_pkg.sv @@
// ----------------------------------------------------------------------------
// piddom_pkg
// Shared types and constants for the PID controller with derivative on
// measurement: register indexes, sequencer states, operation codes, widths.
// ----------------------------------------------------------------------------
package piddom_pkg;

	// feedback history, entries back for the central difference
	localparam int HistDepth = 2;
	localparam int HistPtrW  = (HistDepth > 1) ? $clog2(HistDepth) : 1;

	// port and datapath widths
	localparam int ValW    = 32;   // Q16.16 values
	localparam int GainW   = 24;   // Q8.16 gains
	localparam int CfgIdxW = 3;
	localparam int CfgW    = 32;
	localparam int IntegW  = 48;   // Q32.16 integral
	localparam int MagW    = 48;   // multiplier operand magnitude
	localparam int ChunkW  = 24;   // operand slice per multiplier pass
	localparam int AccW    = 72;   // exact product before the >> 16
	localparam int TermW   = 57;   // signed scaled product
	localparam int TotalW  = 60;   // exact sum of the three terms

	localparam logic signed [IntegW-1:0] IntegMax = {1'b0, {(IntegW-1){1'b1}}};
	localparam logic signed [IntegW-1:0] IntegMin = {1'b1, {(IntegW-1){1'b0}}};
	localparam logic [ValW-1:0] DriveMax = {1'b0, {(ValW-1){1'b1}}};
	localparam logic [ValW-1:0] DriveMin = {1'b1, {(ValW-1){1'b0}}};

	// register indexes on the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		REG_SETPOINT      = 3'd0,
		REG_PROP_GAIN     = 3'd1,
		REG_INTEGRAL_GAIN = 3'd2,
		REG_DERIV_GAIN    = 3'd3,
		REG_SAMPLE_PERIOD = 3'd4,
		REG_DERIV_SCALE   = 3'd5
	} cfg_reg_t;

	// register reset values
	localparam logic signed [ValW-1:0] SetpointRst = '0;
	localparam logic [GainW-1:0] PropGainRst     = 24'd65536;
	localparam logic [GainW-1:0] IntegGainRst    = 24'd0;
	localparam logic [GainW-1:0] DerivGainRst    = 24'd0;
	localparam logic [GainW-1:0] PeriodRst       = 24'd65536;
	localparam logic [CfgW-1:0]  DerivScaleRst   = 32'd32768;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MUL_HI,
		ST_MUL_LO,
		ST_APPLY,
		ST_FINISH
	} state_t;

	// scaled products, in the order they are formed
	typedef enum logic [2:0] {
		OP_INC,    // error * sample_period, into the integral
		OP_DER,    // feedback difference * deriv_scale
		OP_PROP,   // error * prop_gain
		OP_INT,    // integral * integral_gain
		OP_DRV     // derivative * deriv_gain, subtracted
	} op_t;

	function automatic op_t next_op(input op_t op);
		op_t nxt;
		unique case (op)
			OP_INC:  nxt = OP_DER;
			OP_DER:  nxt = OP_PROP;
			OP_PROP: nxt = OP_INT;
			OP_INT:  nxt = OP_DRV;
			OP_DRV:  nxt = OP_DRV;
			default: nxt = OP_DRV;
		endcase
		return nxt;
	endfunction

endpackage

@@ hdl/pid_derivative_on_measurement.sv @@
// ----------------------------------------------------------------------------
// pid_derivative_on_measurement
// PID controller with the derivative taken on the measurement. Five scaled
// products share one 24 x 32 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
// channel   handshake              payload
// -------   --------------------   --------------------------
// input     in_valid / in_ready    feedback
// output    out_valid / out_ready  drive, saturated
// config    cfg_we                 cfg_index, cfg_data
//
// An item passes through an accept step and an operand setup, then for each of
// the five products two multiplier passes and one accumulate, then a saturate
// step. The five products share one multiplier, which takes two passes each.
// in_ready is high only while idle; a result waits in the output register,
// and the block holds in its last step while that register is still full.
// Reset (arst_n low) restores the register defaults and clears history,
// pointer and integral.
//
module pid_derivative_on_measurement
	import piddom_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	// input channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [ValW-1:0]    feedback,
	// output channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [ValW-1:0]    drive,
	output logic                      saturated,
	// configuration
	input  logic                      cfg_we,
	input  logic [CfgIdxW-1:0]        cfg_index,
	input  logic [CfgW-1:0]           cfg_data
);

	// configuration registers
	logic signed [ValW-1:0] setpoint_q;
	logic [GainW-1:0]       prop_gain_q;
	logic [GainW-1:0]       integ_gain_q;
	logic [GainW-1:0]       deriv_gain_q;
	logic [GainW-1:0]       period_q;
	logic [CfgW-1:0]        deriv_scale_q;

	// controller state
	logic signed [ValW-1:0]   hist_q [HistDepth];
	logic [HistPtrW-1:0]      hist_ptr_q;
	logic signed [IntegW-1:0] integral_q;

	// per-item working registers
	logic signed [ValW:0]     error_q;
	logic signed [ValW:0]     diff_q;
	logic signed [MagW:0]     deriv_q;
	logic signed [TotalW-1:0] total_q;

	// shared multiplier unit
	logic [MagW-1:0]  mag_q;
	logic             neg_q;
	logic [CfgW-1:0]  gain_q;
	logic [AccW-1:0]  acc_q;

	// output register
	logic                   out_valid_q;
	logic signed [ValW-1:0] drive_q;
	logic                   sat_q;

	// sequencer
	state_t state_q, state_d;
	op_t    op_q, op_d;
	logic   load_item, load_opnd, mul_hi, mul_lo, apply, finish;

	// combinational datapath signals
	op_t                      sel_op;
	logic signed [MagW:0]     opnd;
	logic [CfgW-1:0]          opnd_gain;
	logic [ChunkW-1:0]        mul_a;
	logic [ChunkW+CfgW-1:0]   prod;
	logic signed [TermW-1:0]  term;
	logic signed [IntegW+9:0] isum;
	logic signed [TotalW-1:0] tsum;
	logic                     isum_ovf;
	logic                     total_ovf;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q    <= SetpointRst;
			prop_gain_q   <= PropGainRst;
			integ_gain_q  <= IntegGainRst;
			deriv_gain_q  <= DerivGainRst;
			period_q      <= PeriodRst;
			deriv_scale_q <= DerivScaleRst;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SETPOINT:      setpoint_q    <= cfg_data;
				REG_PROP_GAIN:     prop_gain_q   <= cfg_data[GainW-1:0];
				REG_INTEGRAL_GAIN: integ_gain_q  <= cfg_data[GainW-1:0];
				REG_DERIV_GAIN:    deriv_gain_q  <= cfg_data[GainW-1:0];
				REG_SAMPLE_PERIOD: period_q      <= cfg_data[GainW-1:0];
				REG_DERIV_SCALE:   deriv_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_INC;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	// next state and step strobes
	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		in_ready  = 1'b0;
		load_item = 1'b0;
		load_opnd = 1'b0;
		mul_hi    = 1'b0;
		mul_lo    = 1'b0;
		apply     = 1'b0;
		finish    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					load_item = 1'b1;
					op_d      = OP_INC;
					state_d   = ST_SETUP;
				end
			end
			ST_SETUP: begin
				load_opnd = 1'b1;
				state_d   = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				mul_hi  = 1'b1;
				state_d = ST_MUL_LO;
			end
			ST_MUL_LO: begin
				mul_lo  = 1'b1;
				state_d = ST_APPLY;
			end
			ST_APPLY: begin
				apply = 1'b1;
				if (op_q == OP_DRV) begin
					state_d = ST_FINISH;
				end else begin
					load_opnd = 1'b1;
					op_d      = next_op(op_q);
					state_d   = ST_MUL_HI;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// operand select for the product about to start
	always_comb begin
		sel_op = (state_q == ST_SETUP) ? op_q : next_op(op_q);
		unique case (sel_op)
			OP_INC: begin
				opnd      = (MagW+1)'(error_q);
				opnd_gain = CfgW'(period_q);
			end
			OP_DER: begin
				opnd      = (MagW+1)'(diff_q);
				opnd_gain = deriv_scale_q;
			end
			OP_PROP: begin
				opnd      = (MagW+1)'(error_q);
				opnd_gain = CfgW'(prop_gain_q);
			end
			OP_INT: begin
				opnd      = (MagW+1)'(integral_q);
				opnd_gain = CfgW'(integ_gain_q);
			end
			OP_DRV: begin
				opnd      = deriv_q;
				opnd_gain = CfgW'(deriv_gain_q);
			end
			default: begin
				opnd      = '0;
				opnd_gain = '0;
			end
		endcase
	end

	// multiplier: upper operand slice first, then the lower one
	assign mul_a = mul_hi ? mag_q[MagW-1:ChunkW] : mag_q[ChunkW-1:0];
	assign prod  = mul_a * gain_q;

	// truncated magnitude with the sign put back, as one add with carry in
	assign term = ({1'b0, acc_q[TermW+14:16]} ^ {TermW{neg_q}}) + TermW'(neg_q);

	// integral update with saturation
	assign isum     = (IntegW+10)'(integral_q) + (IntegW+10)'(term);
	assign isum_ovf = !((&isum[IntegW+9:IntegW-1]) || !(|isum[IntegW+9:IntegW-1]));

	// running sum of the three terms, the derivative term enters negated
	assign tsum      = ((op_q == OP_PROP) ? TotalW'(0) : total_q) + TotalW'(term);
	assign total_ovf = !((&total_q[TotalW-1:ValW-1]) || !(|total_q[TotalW-1:ValW-1]));

	// history, pointer and integral
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HistDepth; i++) begin
				hist_q[i] <= '0;
			end
			hist_ptr_q <= '0;
			integral_q <= '0;
		end else begin
			if (load_item) begin
				hist_q[hist_ptr_q] <= feedback;
				hist_ptr_q <= (hist_ptr_q == HistPtrW'(HistDepth - 1)) ?
					'0 : hist_ptr_q + 1'b1;
			end
			if (apply && op_q == OP_INC) begin
				if (isum_ovf) begin
					integral_q <= isum[IntegW+9] ? IntegMin : IntegMax;
				end else begin
					integral_q <= isum[IntegW-1:0];
				end
			end
		end
	end

	// per-item working registers and multiplier unit
	always_ff @(posedge clk) begin
		if (load_item) begin
			error_q <= (ValW+1)'(setpoint_q) - (ValW+1)'(feedback);
			diff_q  <= (ValW+1)'(feedback) - (ValW+1)'(hist_q[hist_ptr_q]);
		end
		if (load_opnd) begin
			mag_q  <= opnd[MagW] ? MagW'(-opnd) : opnd[MagW-1:0];
			neg_q  <= opnd[MagW] ^ (sel_op == OP_DRV);
			gain_q <= opnd_gain;
		end
		if (mul_hi) begin
			acc_q <= AccW'(prod);
		end else if (mul_lo) begin
			acc_q <= {acc_q[AccW-ChunkW-1:0], {ChunkW{1'b0}}} + AccW'(prod);
		end
		if (apply) begin
			if (op_q == OP_DER) begin
				deriv_q <= term[MagW:0];
			end
			if (op_q == OP_PROP || op_q == OP_INT || op_q == OP_DRV) begin
				total_q <= tsum;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// final saturation to 32 bits
	always_ff @(posedge clk) begin
		if (finish) begin
			if (total_ovf) begin
				drive_q <= total_q[TotalW-1] ? DriveMin : DriveMax;
				sat_q   <= 1'b1;
			end else begin
				drive_q <= total_q[ValW-1:0];
				sat_q   <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign saturated = sat_q;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PID controller with derivative on measurement.
// A directed table covers reset behavior, rails, register masking and spare
// indexes. Random feedback follows under several gain settings, including
// runs into both integral clamps. Every drive and clip flag is checked
// against its typed table value or else a cycle-free controller model.
// ----------------------------------------------------------------------------
module tb;
	import piddom_pkg::*;

	localparam int HalfPeriod   = 6;
	localparam int ResetCycles  = 9;
	localparam int SettleCycles = 24;
	localparam int CycleLimit   = 600000;
	localparam int ReportLimit  = 10;

	// indexes with no register behind them
	localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
	localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

	typedef struct packed {
		logic [ValW-1:0] drive;
		logic            sat;
	} drive_res_t;

	typedef enum {ROW_REG, ROW_FEEDBACK} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [CfgIdxW-1:0] idx;
		logic [CfgW-1:0]    data;
		bit                 typed;
		logic [ValW-1:0]    drive;
		logic               sat;
	} dir_row_t;

	typedef enum {FB_MIXED, FB_LOW_END, FB_HIGH_END} fb_mode_t;
	typedef enum {SET_MIXED, SET_WIND_UP, SET_WIND_DOWN, SET_FULL_SCALE} setting_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [ValW-1:0]   feedback;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [ValW-1:0]   drive;
	logic                     saturated;
	logic                     cfg_we;
	logic [CfgIdxW-1:0]       cfg_index;
	logic [CfgW-1:0]          cfg_data;

	// controller model: registers and state
	logic signed [ValW-1:0]   ctl_setpoint;
	logic [GainW-1:0]         ctl_kp;
	logic [GainW-1:0]         ctl_ki;
	logic [GainW-1:0]         ctl_kd;
	logic [GainW-1:0]         ctl_period;
	logic [CfgW-1:0]          ctl_dscale;
	logic signed [ValW-1:0]   ctl_hist [HistDepth];
	int                       ctl_hist_ptr;
	logic signed [63:0]       ctl_integ;

	drive_res_t               pending_drives [$];
	dir_row_t                 steps [$];
	logic signed [ValW-1:0]   last_fb;

	int                       send_idle_pct;
	int                       recv_idle_pct;
	bit                       dirty;
	int                       mismatches;
	int                       items_sent;
	int                       drives_checked;
	int                       drives_clipped;
	int                       reg_writes;
	int unsigned              cycle_count;

	pid_derivative_on_measurement dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.feedback  (feedback),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive     (drive),
		.saturated (saturated),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		clk = 1'b0;
		#HalfPeriod;
		clk = 1'b1;
		#HalfPeriod;
	end

	// value times unsigned Q.16 factor, magnitude truncated
	function automatic logic signed [63:0] mul_q16(input logic signed [63:0] a,
			input logic [31:0] g);
		logic [63:0]  mag;
		logic [127:0] prod;
		logic [63:0]  r;
		mag  = a[63] ? -a : a;
		prod = {64'd0, mag} * {96'd0, g};
		r    = prod[79:16];
		return a[63] ? -r : r;
	endfunction

	// one controller tick: history, integral, three terms, clip
	task automatic advance_controller(input logic signed [ValW-1:0] fb,
			output drive_res_t res);
		logic signed [ValW-1:0] oldest;
		logic signed [63:0]     err;
		logic signed [63:0]     diff;
		logic signed [63:0]     deriv;
		logic signed [63:0]     total;
		oldest = ctl_hist[ctl_hist_ptr];
		ctl_hist[ctl_hist_ptr] = fb;
		ctl_hist_ptr = (ctl_hist_ptr + 1) % HistDepth;

		err = ctl_setpoint - fb;
		ctl_integ = ctl_integ + mul_q16(err, ctl_period);
		if (ctl_integ > IntegMax)
			ctl_integ = IntegMax;
		if (ctl_integ < IntegMin)
			ctl_integ = IntegMin;

		diff  = fb - oldest;
		deriv = mul_q16(diff, ctl_dscale);
		total = mul_q16(err, ctl_kp) + mul_q16(ctl_integ, ctl_ki) - mul_q16(deriv, ctl_kd);

		res.sat = 1'b0;
		if (total > $signed(DriveMax)) begin
			total   = $signed(DriveMax);
			res.sat = 1'b1;
		end
		if (total < $signed(DriveMin)) begin
			total   = $signed(DriveMin);
			res.sat = 1'b1;
		end
		res.drive = total[ValW-1:0];
	endtask

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= ReportLimit)
			$display("%s", msg);
	endtask

	// one register write, model updated alongside
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_SETPOINT:      ctl_setpoint = data;
			REG_PROP_GAIN:     ctl_kp       = data[GainW-1:0];
			REG_INTEGRAL_GAIN: ctl_ki       = data[GainW-1:0];
			REG_DERIV_GAIN:    ctl_kd       = data[GainW-1:0];
			REG_SAMPLE_PERIOD: ctl_period   = data[GainW-1:0];
			REG_DERIV_SCALE:   ctl_dscale   = data;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
	endtask

	// one feedback transfer; typed expectation overrides the model result
	task automatic send_feedback(input logic signed [ValW-1:0] fb, input bit typed,
			input logic [ValW-1:0] typed_drive, input logic typed_sat);
		drive_res_t predicted;
		cfg_we <= 1'b0;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		feedback <= fb;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		advance_controller(fb, predicted);
		if (typed)
			pending_drives.push_back({typed_drive, typed_sat});
		else
			pending_drives.push_back(predicted);
		items_sent++;
		dirty = 1'b1;
		@(negedge clk);
	endtask

	// drain all results and let the sequencer go idle
	task automatic settle_block;
		if (dirty) begin
			in_valid <= 1'b0;
			while (pending_drives.size() != 0)
				@(negedge clk);
			repeat (SettleCycles) @(negedge clk);
			dirty = 1'b0;
		end
	endtask

	function automatic logic [CfgW-1:0] pick_reg_data;
		logic [CfgW-1:0] v;
		case ($urandom_range(0, 3))
			0: v = '0;
			1: v = $urandom | 32'h00FF_FFFF;
			2: v = $urandom & 32'hFF02_FFFF;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic program_setting(input setting_t style);
		settle_block();
		case (style)
			SET_WIND_UP, SET_WIND_DOWN: begin
				write_reg(REG_SETPOINT, (style == SET_WIND_UP) ? DriveMax : DriveMin);
				write_reg(REG_PROP_GAIN, '0);
				write_reg(REG_INTEGRAL_GAIN, 32'd1);
				write_reg(REG_DERIV_GAIN, '0);
				write_reg(REG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
				write_reg(REG_DERIV_SCALE, $urandom);
			end
			SET_FULL_SCALE: begin
				write_reg(REG_SETPOINT, $urandom);
				write_reg(REG_PROP_GAIN, 32'hFFFF_FFFF);
				write_reg(REG_INTEGRAL_GAIN, 32'hFFFF_FFFF);
				write_reg(REG_DERIV_GAIN, 32'hFFFF_FFFF);
				write_reg(REG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
				write_reg(REG_DERIV_SCALE, 32'hFFFF_FFFF);
			end
			default: begin
				write_reg(REG_SETPOINT, pick_reg_data());
				write_reg(REG_PROP_GAIN, pick_reg_data());
				write_reg(REG_INTEGRAL_GAIN, pick_reg_data());
				write_reg(REG_DERIV_GAIN, pick_reg_data());
				write_reg(REG_SAMPLE_PERIOD, pick_reg_data());
				write_reg(REG_DERIV_SCALE, pick_reg_data());
				if ($urandom_range(0, 1) == 0)
					write_reg($urandom_range(0, 1) ? RegSpareHi : RegSpareLo, $urandom);
			end
		endcase
	endtask

	// random feedback: rails, slow drift around the last value, or anything
	task automatic run_segment(input int count, input fb_mode_t mode);
		logic signed [ValW-1:0] fb;
		for (int k = 0; k < count; k++) begin
			case (mode)
				FB_LOW_END:  fb = DriveMin + $urandom_range(0, 32'h0FFF_FFFF);
				FB_HIGH_END: fb = DriveMax - $urandom_range(0, 32'h0FFF_FFFF);
				default: begin
					case ($urandom_range(0, 7))
						0: begin
							case ($urandom_range(0, 3))
								0: fb = DriveMin;
								1: fb = DriveMax;
								2: fb = '0;
								default: fb = '1;
							endcase
						end
						1, 2, 3: fb = last_fb + ($urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000);
						default: fb = $urandom;
					endcase
				end
			endcase
			last_fb = fb;
			send_feedback(fb, 1'b0, '0, 1'b0);
		end
	endtask

	task automatic add_write(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
		dir_row_t r;
		r.kind  = ROW_REG;
		r.idx   = idx;
		r.data  = data;
		r.typed = 1'b0;
		r.drive = '0;
		r.sat   = 1'b0;
		steps.push_back(r);
	endtask

	task automatic add_sample(input logic [ValW-1:0] fb, input bit typed,
			input logic [ValW-1:0] exp_drive, input logic exp_sat);
		dir_row_t r;
		r.kind  = ROW_FEEDBACK;
		r.idx   = '0;
		r.data  = fb;
		r.typed = typed;
		r.drive = exp_drive;
		r.sat   = exp_sat;
		steps.push_back(r);
	endtask

	// receiver stalls
	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// result checker
	always @(posedge clk) begin : drive_monitor
		drive_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_drives.size() == 0) begin
				note_mismatch($sformatf("cycle %0d: unexpected drive %h sat %b",
					cycle_count, drive, saturated));
			end else begin
				want = pending_drives.pop_front();
				drives_checked++;
				if (saturated === 1'b1)
					drives_clipped++;
				if (drive !== want.drive || saturated !== want.sat)
					note_mismatch($sformatf(
						"cycle %0d: drive %h sat %b, expected drive %h sat %b",
						cycle_count, drive, saturated, want.drive, want.sat));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("no progress after %0d cycles, %0d drives outstanding",
				cycle_count, pending_drives.size());
			$display("pid_derivative_on_measurement: mismatch");
			$finish;
		end
	end

	initial begin
		in_valid       = 1'b0;
		feedback       = '0;
		out_ready      = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		arst_n         = 1'b0;
		cycle_count    = 0;
		mismatches     = 0;
		items_sent     = 0;
		drives_checked = 0;
		drives_clipped = 0;
		reg_writes     = 0;
		last_fb        = '0;
		dirty          = 1'b1;
		send_idle_pct  = 13;
		recv_idle_pct  = 53;

		// model reset state
		ctl_setpoint = SetpointRst;
		ctl_kp       = PropGainRst;
		ctl_ki       = IntegGainRst;
		ctl_kd       = DerivGainRst;
		ctl_period   = PeriodRst;
		ctl_dscale   = DerivScaleRst;
		for (int i = 0; i < HistDepth; i++)
			ctl_hist[i] = '0;
		ctl_hist_ptr = 0;
		ctl_integ    = '0;

		repeat (ResetCycles) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// derivative alone, first samples see an empty history
		add_write(REG_PROP_GAIN, '0);
		add_write(REG_DERIV_GAIN, 32'd65536);
		add_sample(32'd65536, 1'b1, 32'hFFFF_8000, 1'b0);
		add_sample(32'd131072, 1'b1, 32'hFFFF_0000, 1'b0);
		add_sample(32'd131072, 1'b0, '0, 1'b0);
		add_sample(32'hFFFF_0000, 1'b0, '0, 1'b0);
		// unity proportional, drive equals error up to the rails
		add_write(REG_PROP_GAIN, 32'd65536);
		add_write(REG_DERIV_GAIN, '0);
		add_sample(32'd0, 1'b1, 32'd0, 1'b0);
		add_sample(32'd65536, 1'b1, 32'hFFFF_0000, 1'b0);
		add_sample(DriveMin, 1'b1, DriveMax, 1'b1);
		add_sample(DriveMax, 1'b1, 32'h8000_0001, 1'b0);
		add_write(REG_SETPOINT, DriveMax);
		add_sample(DriveMin, 1'b1, DriveMax, 1'b1);
		add_write(REG_SETPOINT, DriveMin);
		add_sample(DriveMax, 1'b1, DriveMin, 1'b1);
		add_sample(DriveMin, 1'b1, 32'd0, 1'b0);
		// bits above the gain width and spare indexes change nothing
		add_write(REG_PROP_GAIN, 32'hFF00_0000);
		add_write(RegSpareLo, 32'h00FF_FFFF);
		add_write(RegSpareHi, 32'h0001_0000);
		add_sample(32'd12345678, 1'b1, 32'd0, 1'b0);
		// zero period freezes the integral
		add_write(REG_INTEGRAL_GAIN, 32'h00FF_FFFF);
		add_write(REG_SAMPLE_PERIOD, '0);
		add_sample(32'h4000_0000, 1'b0, '0, 1'b0);
		// all gains and the derivative scale at their top
		add_write(REG_DERIV_SCALE, 32'hFFFF_FFFF);
		add_write(REG_DERIV_GAIN, 32'h00FF_FFFF);
		add_write(REG_PROP_GAIN, 32'h00FF_FFFF);
		add_write(REG_SETPOINT, '0);
		add_sample(DriveMax, 1'b0, '0, 1'b0);
		add_sample(DriveMin, 1'b0, '0, 1'b0);
		add_sample(32'd0, 1'b0, '0, 1'b0);
		add_write(REG_SAMPLE_PERIOD, 32'h00FF_FFFF);
		add_write(REG_INTEGRAL_GAIN, 32'd1);
		add_sample(DriveMin, 1'b0, '0, 1'b0);
		add_sample(32'hFFFF_FFFF, 1'b0, '0, 1'b0);

		foreach (steps[n]) begin
			if (steps[n].kind == ROW_REG) begin
				settle_block();
				write_reg(steps[n].idx, steps[n].data);
			end else begin
				send_feedback(steps[n].data, steps[n].typed, steps[n].drive, steps[n].sat);
			end
		end

		// sender seldom idle, receiver often stalled
		program_setting(SET_MIXED);
		run_segment(100, FB_MIXED);
		program_setting(SET_WIND_UP);
		run_segment(160, FB_LOW_END);

		// roles swapped, integral walked down to the other clamp
		settle_block();
		send_idle_pct = 53;
		recv_idle_pct = 13;
		program_setting(SET_WIND_DOWN);
		run_segment(280, FB_HIGH_END);

		// back to back on both sides
		settle_block();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		program_setting(SET_MIXED);
		run_segment(60, FB_MIXED);
		program_setting(SET_FULL_SCALE);
		run_segment(40, FB_MIXED);
		program_setting(SET_MIXED);
		run_segment(80, FB_MIXED);

		settle_block();
		$display("covered %0d feedback transfers over %0d register writes, %0d drives checked",
			items_sent, reg_writes, drives_checked);
		$display("%0d drives clipped, %0d mismatches, %0d cycles",
			drives_clipped, mismatches, cycle_count);
		if (mismatches == 0)
			$display("pid_derivative_on_measurement: match");
		else
			$display("pid_derivative_on_measurement: mismatch");
		$finish;
	end

endmodule
